[src/plpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpd_pkg
// Shared widths, codes, payload types and saturation helper for the
// point/line/plane distance pipeline.
// ----------------------------------------------------------------------------
package plpd_pkg;

   localparam int COORD_BITS_DEFAULT = 16;

   localparam int D_W     = 18;   // saturated difference, Q9.8
   localparam int U_W     = 16;   // unit component, Q1.14
   localparam int PROD_W  = 34;
   localparam int DOT_W   = 36;   // Q.22
   localparam int PROJ_W  = 52;   // Q.36
   localparam int DELTA_W = 25;
   localparam int SQ_W    = 50;
   localparam int SUM_W   = 52;
   localparam int ROOT_W  = SUM_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int OUT_W   = 18;
   localparam int IDX_W   = 3;

   localparam logic [1:0] KIND_POINT   = 2'd0;
   localparam logic [1:0] KIND_LINE    = 2'd1;
   localparam logic [1:0] KIND_PLANE   = 2'd2;
   localparam logic [1:0] KIND_INVALID = 2'd3;

   localparam logic [IDX_W-1:0] REG_KIND   = 3'd0;
   localparam logic [IDX_W-1:0] REG_REF_X  = 3'd1;
   localparam logic [IDX_W-1:0] REG_REF_Y  = 3'd2;
   localparam logic [IDX_W-1:0] REG_REF_Z  = 3'd3;
   localparam logic [IDX_W-1:0] REG_UNIT_X = 3'd4;
   localparam logic [IDX_W-1:0] REG_UNIT_Y = 3'd5;
   localparam logic [IDX_W-1:0] REG_UNIT_Z = 3'd6;

   localparam logic signed [OUT_W-1:0] OUT_MAX      = 18'sd131071;
   localparam logic signed [OUT_W-1:0] OUT_MIN      = -18'sd131072;
   localparam logic signed [OUT_W-1:0] MINUS_ONE_Q8 = -18'sd256;

   typedef struct packed {
      logic [1:0]             kind;
      logic signed [U_W-1:0]  unit_x;
      logic signed [U_W-1:0]  unit_y;
      logic signed [U_W-1:0]  unit_z;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic signed [DELTA_W-1:0] delta_z;
      logic signed [OUT_W-1:0]   plane_dist;
   } mid_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] distance;
      logic signed [OUT_W-1:0] delta_x;
      logic signed [OUT_W-1:0] delta_y;
      logic signed [OUT_W-1:0] delta_z;
      logic                    bad_kind;
   } result_type;

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > 64'(OUT_MAX)) begin
         r = OUT_MAX;
      end else if (v < 64'(OUT_MIN)) begin
         r = OUT_MIN;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

[src/point_line_plane_distance.sv]
`timescale 1ns / 1ps
// One position per cycle while req_tready is high; the 26-stage square root sets the depth.
// req_tready drops only when the two-entry output buffer is full.
// Reset (synchronous, active high) empties the pipeline and sets the
// reference to a point at the origin with unit vector (1.0, 0, 0).
// ----------------------------------------------------------------------------
// point_line_plane_distance
// Distance and offset of a 3D position from a configured point, line or plane.
// ----------------------------------------------------------------------------
module point_line_plane_distance #(
   parameter int COORD_BITS = plpd_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pos_x, pos_y, pos_z
   input  logic [((3*COORD_BITS+7)/8)*8-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // distance, delta_x, delta_y, delta_z
   output logic [4*plpd_pkg::OUT_W-1:0]        rsp_tdata,
   // bad_kind
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [plpd_pkg::IDX_W-1:0]          csr_index,
   input  logic [(COORD_BITS > 16 ? COORD_BITS : 16)-1:0] csr_wdata
);

   logic signed [COORD_BITS-1:0]  ref_x_ff;
   logic signed [COORD_BITS-1:0]  ref_y_ff;
   logic signed [COORD_BITS-1:0]  ref_z_ff;
   plpd_pkg::cfg_type             cfg_ff;
   logic                          en;
   logic                          mid_valid;
   plpd_pkg::mid_type             mid;
   logic                          res_valid;
   plpd_pkg::result_type          res;
   plpd_pkg::result_type          rsp_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kind   <= plpd_pkg::KIND_POINT;
         cfg_ff.unit_x <= 16'sd16384;
         cfg_ff.unit_y <= '0;
         cfg_ff.unit_z <= '0;
         ref_x_ff      <= '0;
         ref_y_ff      <= '0;
         ref_z_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            plpd_pkg::REG_KIND:   cfg_ff.kind   <= csr_wdata[1:0];
            plpd_pkg::REG_REF_X:  ref_x_ff      <= csr_wdata[COORD_BITS-1:0];
            plpd_pkg::REG_REF_Y:  ref_y_ff      <= csr_wdata[COORD_BITS-1:0];
            plpd_pkg::REG_REF_Z:  ref_z_ff      <= csr_wdata[COORD_BITS-1:0];
            plpd_pkg::REG_UNIT_X: cfg_ff.unit_x <= csr_wdata[15:0];
            plpd_pkg::REG_UNIT_Y: cfg_ff.unit_y <= csr_wdata[15:0];
            plpd_pkg::REG_UNIT_Z: cfg_ff.unit_z <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = en;

   plpd_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .pos_x     (req_tdata[COORD_BITS-1:0]),
      .pos_y     (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .pos_z     (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .ref_x     (ref_x_ff),
      .ref_y     (ref_y_ff),
      .ref_z     (ref_z_ff),
      .cfg       (cfg_ff),
      .out_valid (mid_valid),
      .out_mid   (mid)
   );

   plpd_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mid_valid),
      .in_mid    (mid),
      .out_valid (res_valid),
      .out_res   (res)
   );

   plpd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_ready  (en),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_res),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {rsp_res.delta_z, rsp_res.delta_y, rsp_res.delta_x, rsp_res.distance};
   assign rsp_tuser = rsp_res.bad_kind;

   // a full spare entry implies a waiting result
   a_spare_needs_main: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("output buffer spare full without main entry");

   a_bad_kind_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == {54'd0, plpd_pkg::MINUS_ONE_Q8})
      else $error("invalid kind result not -1 with zero offset");

   a_stall_holds_buffer: assert property (@(posedge clock) disable iff (reset)
      !req_tready && !rsp_tready |=> !req_tready)
      else $error("output buffer released without a transfer");

endmodule

[src/plpd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpd_front
// Difference, dot product and projection stages: five registered stages
// producing the offset vector and the plane distance.
// ----------------------------------------------------------------------------
module plpd_front #(
   parameter int COORD_BITS = plpd_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [COORD_BITS-1:0]  pos_x,
   input  logic signed [COORD_BITS-1:0]  pos_y,
   input  logic signed [COORD_BITS-1:0]  pos_z,
   input  logic signed [COORD_BITS-1:0]  ref_x,
   input  logic signed [COORD_BITS-1:0]  ref_y,
   input  logic signed [COORD_BITS-1:0]  ref_z,
   input  plpd_pkg::cfg_type             cfg,
   output logic                          out_valid,
   output plpd_pkg::mid_type             out_mid
);

   logic signed [COORD_BITS:0]                 diff [3];
   logic signed [plpd_pkg::U_W-1:0]            unit [3];
   logic signed [plpd_pkg::D_W-1:0]            d_in [3];
   logic signed [plpd_pkg::D_W-1:0]            s1_d_ff [3];
   logic signed [plpd_pkg::D_W-1:0]            s2_d_ff [3];
   logic signed [plpd_pkg::D_W-1:0]            s3_d_ff [3];
   logic signed [plpd_pkg::D_W-1:0]            s4_d_ff [3];
   logic signed [plpd_pkg::PROD_W-1:0]         s2_prod_ff [3];
   logic signed [plpd_pkg::DOT_W-1:0]          s3_dot_ff;
   logic signed [plpd_pkg::DOT_W-1:0]          s3_dot_in;
   logic signed [plpd_pkg::DOT_W-1:0]          s4_dot_ff;
   logic signed [plpd_pkg::PROJ_W-1:0]         s4_proj_ff [3];
   logic signed [plpd_pkg::PROJ_W:0]           proj_rnd [3];
   logic signed [plpd_pkg::DELTA_W-1:0]        proj_q8 [3];
   logic signed [plpd_pkg::DELTA_W-1:0]        delta_in [3];
   logic signed [plpd_pkg::DOT_W:0]            dot_rnd;
   logic [4:0]                                 v_ff;
   plpd_pkg::mid_type                          mid_ff;
   plpd_pkg::mid_type                          mid_in;

   assign unit[0] = cfg.unit_x;
   assign unit[1] = cfg.unit_y;
   assign unit[2] = cfg.unit_z;

   assign diff[0] = (COORD_BITS+1)'(ref_x) - (COORD_BITS+1)'(pos_x);
   assign diff[1] = (COORD_BITS+1)'(ref_y) - (COORD_BITS+1)'(pos_y);
   assign diff[2] = (COORD_BITS+1)'(ref_z) - (COORD_BITS+1)'(pos_z);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in[i] = plpd_pkg::sat_out(64'(diff[i]));
      end
   end

   assign s3_dot_in = plpd_pkg::DOT_W'(s2_prod_ff[0]) + plpd_pkg::DOT_W'(s2_prod_ff[1])
                    + plpd_pkg::DOT_W'(s2_prod_ff[2]);

   // round half up to Q.8
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         proj_rnd[i] = (plpd_pkg::PROJ_W+1)'(s4_proj_ff[i])
                     + ((plpd_pkg::PROJ_W+1)'(1) <<< 27);
         proj_q8[i]  = $signed(proj_rnd[i][plpd_pkg::PROJ_W:28]);
      end
   end

   assign dot_rnd = (plpd_pkg::DOT_W+1)'(s4_dot_ff) + ((plpd_pkg::DOT_W+1)'(1) <<< 13);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (cfg.kind)
            plpd_pkg::KIND_POINT: begin
               delta_in[i] = plpd_pkg::DELTA_W'(s4_d_ff[i]);
            end
            plpd_pkg::KIND_LINE: begin
               delta_in[i] = plpd_pkg::DELTA_W'(s4_d_ff[i]) - proj_q8[i];
            end
            default: begin
               delta_in[i] = proj_q8[i];
            end
         endcase
      end
      mid_in.kind       = cfg.kind;
      mid_in.delta_x    = delta_in[0];
      mid_in.delta_y    = delta_in[1];
      mid_in.delta_z    = delta_in[2];
      mid_in.plane_dist = plpd_pkg::sat_out(64'($signed(dot_rnd[plpd_pkg::DOT_W:14])));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_d_ff[i]    <= d_in[i];
            s2_d_ff[i]    <= s1_d_ff[i];
            s2_prod_ff[i] <= s1_d_ff[i] * unit[i];
            s3_d_ff[i]    <= s2_d_ff[i];
            s4_d_ff[i]    <= s3_d_ff[i];
            s4_proj_ff[i] <= s3_dot_ff * unit[i];
         end
         s3_dot_ff <= s3_dot_in;
         s4_dot_ff <= s3_dot_ff;
         mid_ff    <= mid_in;
      end
   end

   assign out_valid = v_ff[4];
   assign out_mid   = mid_ff;

endmodule

[src/plpd_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpd_norm
// Sum of squares, pipelined bit-per-stage square root with rounding, and
// final selection of the result by reference kind.
// ----------------------------------------------------------------------------
module plpd_norm (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  plpd_pkg::mid_type       in_mid,
   output logic                    out_valid,
   output plpd_pkg::result_type    out_res
);

   localparam int NS = plpd_pkg::ROOT_W;

   logic signed [plpd_pkg::SQ_W-1:0]   sq_ff [3];
   logic [plpd_pkg::SUM_W-1:0]         sum_ff;
   logic                               sq_v_ff;
   logic                               sum_v_ff;
   plpd_pkg::mid_type                  sq_mid_ff;
   plpd_pkg::mid_type                  sum_mid_ff;

   logic [plpd_pkg::REM_W-1:0]         rt_rem_ff [NS];
   logic [plpd_pkg::ROOT_W-1:0]        rt_q_ff   [NS];
   logic [plpd_pkg::SUM_W-1:0]         rt_s_ff   [NS];
   plpd_pkg::mid_type                  rt_mid_ff [NS];
   logic [NS-1:0]                      rt_v_ff;

   logic [plpd_pkg::ROOT_W:0]          root_rnd;
   logic signed [plpd_pkg::OUT_W-1:0]  root_sat;
   plpd_pkg::mid_type                  fin_mid;
   plpd_pkg::result_type               res_in;
   plpd_pkg::result_type               res_ff;
   logic                               res_v_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0]   <= in_mid.delta_x * in_mid.delta_x;
         sq_ff[1]   <= in_mid.delta_y * in_mid.delta_y;
         sq_ff[2]   <= in_mid.delta_z * in_mid.delta_z;
         sq_mid_ff  <= in_mid;
         sum_ff     <= plpd_pkg::SUM_W'(unsigned'(sq_ff[0]))
                     + plpd_pkg::SUM_W'(unsigned'(sq_ff[1]))
                     + plpd_pkg::SUM_W'(unsigned'(sq_ff[2]));
         sum_mid_ff <= sq_mid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff  <= 1'b0;
         sum_v_ff <= 1'b0;
         rt_v_ff  <= '0;
         res_v_ff <= 1'b0;
      end else if (en) begin
         sq_v_ff  <= in_valid;
         sum_v_ff <= sq_v_ff;
         rt_v_ff  <= {rt_v_ff[NS-2:0], sum_v_ff};
         res_v_ff <= rt_v_ff[NS-1];
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_root
      logic [plpd_pkg::REM_W-1:0]  rem_prev;
      logic [plpd_pkg::ROOT_W-1:0] q_prev;
      logic [plpd_pkg::SUM_W-1:0]  s_prev;
      plpd_pkg::mid_type           mid_prev;
      logic [plpd_pkg::REM_W+1:0]  rem_sh;
      logic [plpd_pkg::REM_W+1:0]  trial;
      logic                        fits;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign q_prev   = '0;
         assign s_prev   = sum_ff;
         assign mid_prev = sum_mid_ff;
      end else begin : g_next
         assign rem_prev = rt_rem_ff[k-1];
         assign q_prev   = rt_q_ff[k-1];
         assign s_prev   = rt_s_ff[k-1];
         assign mid_prev = rt_mid_ff[k-1];
      end

      assign rem_sh = {rem_prev, s_prev[plpd_pkg::SUM_W-1 -: 2]};
      assign trial  = (plpd_pkg::REM_W+2)'({q_prev, 2'b01});
      assign fits   = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rt_rem_ff[k] <= fits ? plpd_pkg::REM_W'(rem_sh - trial)
                                 : plpd_pkg::REM_W'(rem_sh);
            rt_q_ff[k]   <= {q_prev[plpd_pkg::ROOT_W-2:0], fits};
            rt_s_ff[k]   <= {s_prev[plpd_pkg::SUM_W-3:0], 2'b00};
            rt_mid_ff[k] <= mid_prev;
         end
      end
   end

   // remainder above the root means the true root is nearer q+1
   assign root_rnd = {1'b0, rt_q_ff[NS-1]}
                   + ((rt_rem_ff[NS-1] > plpd_pkg::REM_W'(rt_q_ff[NS-1]))
                      ? (plpd_pkg::ROOT_W+1)'(1) : '0);
   assign root_sat = (root_rnd > (plpd_pkg::ROOT_W+1)'(plpd_pkg::OUT_MAX))
                   ? plpd_pkg::OUT_MAX : root_rnd[plpd_pkg::OUT_W-1:0];
   assign fin_mid  = rt_mid_ff[NS-1];

   always_comb begin
      res_in.distance = root_sat;
      res_in.delta_x  = plpd_pkg::sat_out(64'(fin_mid.delta_x));
      res_in.delta_y  = plpd_pkg::sat_out(64'(fin_mid.delta_y));
      res_in.delta_z  = plpd_pkg::sat_out(64'(fin_mid.delta_z));
      res_in.bad_kind = 1'b0;
      case (fin_mid.kind)
         plpd_pkg::KIND_POINT, plpd_pkg::KIND_LINE: begin
         end
         plpd_pkg::KIND_PLANE: begin
            res_in.distance = fin_mid.plane_dist;
         end
         default: begin
            res_in.distance = plpd_pkg::MINUS_ONE_Q8;
            res_in.delta_x  = '0;
            res_in.delta_y  = '0;
            res_in.delta_z  = '0;
            res_in.bad_kind = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = res_v_ff;
   assign out_res   = res_ff;

endmodule

[src/plpd_skid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpd_skid
// Two-entry output buffer; its ready is registered and holds the pipeline.
// ----------------------------------------------------------------------------
module plpd_skid (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  plpd_pkg::result_type    in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output plpd_pkg::result_type    out_data,
   input  logic                    out_ready
);

   logic                  main_v_ff;
   logic                  spare_v_ff;
   plpd_pkg::result_type  main_ff;
   plpd_pkg::result_type  spare_ff;
   logic                  take;
   logic                  free;

   assign take = in_valid & ~spare_v_ff;
   assign free = ~main_v_ff | out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff  <= 1'b0;
         spare_v_ff <= 1'b0;
      end else if (free) begin
         if (spare_v_ff) begin
            main_v_ff  <= 1'b1;
            spare_v_ff <= 1'b0;
         end else begin
            main_v_ff <= take;
         end
      end else if (take) begin
         spare_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (free) begin
         main_ff <= spare_v_ff ? spare_ff : in_data;
      end else if (take) begin
         spare_ff <= in_data;
      end
   end

   assign in_ready  = ~spare_v_ff;
   assign out_valid = main_v_ff;
   assign out_data  = main_ff;

endmodule

[bench/point_line_plane_distance_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_line_plane_distance_tb
// Streams query positions through the distance pipeline under a series of
// reference settings (point, line, plane, invalid kind, non-unit vectors),
// predicts every result in the bench and checks each rsp_ transfer in order.
// Both handshakes idle at random, with one stretch of full throughput.
// ----------------------------------------------------------------------------
module point_line_plane_distance_tb;

   localparam int  CYCLE_LIMIT = 400000;
   localparam int  CALM_FROM   = 1200;
   localparam int  CALM_TO     = 2000;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } position_type;

   logic                          clock;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [47:0]                   req_tdata  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [71:0]                   rsp_tdata;
   logic                          rsp_tuser;
   logic                          csr_we     = 1'b0;
   logic [plpd_pkg::IDX_W-1:0]    csr_index  = '0;
   logic [15:0]                   csr_wdata  = '0;

   position_type                  pending_pos[$];
   plpd_pkg::result_type          expected_res[$];
   position_type                  cur_pos;
   logic                          hold_sender = 1'b0;
   logic                          failed = 1'b0;
   int                            cycle_count = 0;

   logic [1:0]                    cfg_kind;
   logic signed [15:0]            cfg_ref[3];
   logic signed [15:0]            cfg_unit[3];

   point_line_plane_distance u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint clip18(longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
   endfunction

   function automatic longint round_half_up(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint root_nearest(longint s);
      longint r;
      longint x;
      longint b;
      r = 0;
      x = s;
      b = longint'(1) << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (s - r * r > r) r = r + 1;
      return r;
   endfunction

   function automatic plpd_pkg::result_type measure_offset(position_type p);
      longint               diff[3];
      longint               uv[3];
      longint               off[3];
      longint               pv[3];
      longint               dot;
      longint               span;
      plpd_pkg::result_type res;
      pv[0] = p.x; pv[1] = p.y; pv[2] = p.z;
      dot  = 0;
      span = -256;
      for (int i = 0; i < 3; i++) begin
         uv[i]   = cfg_unit[i];
         diff[i] = clip18(longint'(cfg_ref[i]) - pv[i]);
         dot     = dot + uv[i] * diff[i];
         off[i]  = 0;
      end
      res.bad_kind = 1'b0;
      case (cfg_kind)
         plpd_pkg::KIND_POINT: begin
            for (int i = 0; i < 3; i++) off[i] = diff[i];
            span = clip18(root_nearest(off[0]*off[0] + off[1]*off[1] + off[2]*off[2]));
         end
         plpd_pkg::KIND_LINE: begin
            for (int i = 0; i < 3; i++)
               off[i] = diff[i] - round_half_up(dot * uv[i], 28);
            span = clip18(root_nearest(off[0]*off[0] + off[1]*off[1] + off[2]*off[2]));
         end
         plpd_pkg::KIND_PLANE: begin
            span = clip18(round_half_up(dot, 14));
            for (int i = 0; i < 3; i++) off[i] = round_half_up(dot * uv[i], 28);
         end
         default: res.bad_kind = 1'b1;
      endcase
      res.distance = span[17:0];
      res.delta_x  = 18'(clip18(off[0]));
      res.delta_y  = 18'(clip18(off[1]));
      res.delta_z  = 18'(clip18(off[2]));
      return res;
   endfunction

   function automatic logic idle_now();
      if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) return 1'b0;
      return ($urandom_range(99) < 13);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_res.push_back(measure_offset(cur_pos));
         if (!req_tvalid || req_tready) begin
            if (pending_pos.size() > 0 && !hold_sender && !idle_now()) begin
               cur_pos    <= pending_pos[0];
               req_tdata  <= {pending_pos[0].z, pending_pos[0].y, pending_pos[0].x};
               req_tvalid <= 1'b1;
               void'(pending_pos.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      plpd_pkg::result_type exp_r;
      logic                 miss;
      miss = 1'b0;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_res.size() == 0) begin
               $error("result transfer with nothing expected");
               miss = 1'b1;
            end else begin
               exp_r = expected_res.pop_front();
               if (rsp_tdata[17:0] !== exp_r.distance) begin
                  $error("distance: expected %0d, got %0d", exp_r.distance,
                         $signed(rsp_tdata[17:0]));
                  miss = 1'b1;
               end
               if (rsp_tdata[35:18] !== exp_r.delta_x) begin
                  $error("delta_x: expected %0d, got %0d", exp_r.delta_x,
                         $signed(rsp_tdata[35:18]));
                  miss = 1'b1;
               end
               if (rsp_tdata[53:36] !== exp_r.delta_y) begin
                  $error("delta_y: expected %0d, got %0d", exp_r.delta_y,
                         $signed(rsp_tdata[53:36]));
                  miss = 1'b1;
               end
               if (rsp_tdata[71:54] !== exp_r.delta_z) begin
                  $error("delta_z: expected %0d, got %0d", exp_r.delta_z,
                         $signed(rsp_tdata[71:54]));
                  miss = 1'b1;
               end
               if (rsp_tuser !== exp_r.bad_kind) begin
                  $error("bad_kind: expected %0b, got %0b", exp_r.bad_kind, rsp_tuser);
                  miss = 1'b1;
               end
            end
         end
         if (miss) failed <= 1'b1;
         rsp_tready <= !idle_now();
      end
   end

   task automatic wait_drained();
      while (pending_pos.size() > 0 || req_tvalid || expected_res.size() > 0)
         @(posedge clock);
   endtask

   task automatic write_reg(logic [plpd_pkg::IDX_W-1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         plpd_pkg::REG_KIND:   cfg_kind    = val[1:0];
         plpd_pkg::REG_REF_X:  cfg_ref[0]  = val;
         plpd_pkg::REG_REF_Y:  cfg_ref[1]  = val;
         plpd_pkg::REG_REF_Z:  cfg_ref[2]  = val;
         plpd_pkg::REG_UNIT_X: cfg_unit[0] = val;
         plpd_pkg::REG_UNIT_Y: cfg_unit[1] = val;
         plpd_pkg::REG_UNIT_Z: cfg_unit[2] = val;
         default: ;
      endcase
   endtask

   task automatic set_reference(logic [1:0] kind, logic [15:0] rx, logic [15:0] ry,
                                logic [15:0] rz, logic [15:0] ux, logic [15:0] uy,
                                logic [15:0] uz);
      wait_drained();
      write_reg(plpd_pkg::REG_KIND, 16'(kind));
      write_reg(plpd_pkg::REG_REF_X, rx);
      write_reg(plpd_pkg::REG_REF_Y, ry);
      write_reg(plpd_pkg::REG_REF_Z, rz);
      write_reg(plpd_pkg::REG_UNIT_X, ux);
      write_reg(plpd_pkg::REG_UNIT_Y, uy);
      write_reg(plpd_pkg::REG_UNIT_Z, uz);
   endtask

   function automatic logic [15:0] rand_unit();
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   // full-range positions mixed with positions near the reference
   task automatic queue_random(int n);
      position_type p;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(1)) begin
            p.x = 16'($urandom); p.y = 16'($urandom); p.z = 16'($urandom);
         end else begin
            p.x = cfg_ref[0] + 16'($signed($urandom_range(4096)) - 2048);
            p.y = cfg_ref[1] + 16'($signed($urandom_range(4096)) - 2048);
            p.z = cfg_ref[2] + 16'($signed($urandom_range(4096)) - 2048);
         end
         pending_pos.push_back(p);
      end
   endtask

   task automatic queue_corners();
      position_type p;
      for (int c = 0; c < 8; c++) begin
         p.x = c[0] ? 16'sh7FFF : 16'sh8000;
         p.y = c[1] ? 16'sh7FFF : 16'sh8000;
         p.z = c[2] ? 16'sh7FFF : 16'sh8000;
         pending_pos.push_back(p);
      end
      p.x = cfg_ref[0]; p.y = cfg_ref[1]; p.z = cfg_ref[2];
      pending_pos.push_back(p);
   endtask

   initial begin
      cfg_kind = plpd_pkg::KIND_POINT;
      cfg_ref[0] = 0; cfg_ref[1] = 0; cfg_ref[2] = 0;
      cfg_unit[0] = 16384; cfg_unit[1] = 0; cfg_unit[2] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset reference: point at origin
      queue_corners();
      queue_random(150);

      set_reference(plpd_pkg::KIND_POINT, 16'h8000, 16'h7FFF, 16'h8000, 16384, 0, 0);
      queue_corners();
      queue_random(150);

      set_reference(plpd_pkg::KIND_LINE, 16'h0100, 16'hFF00, 16'h0000, 0, 16384, 0);
      queue_corners();
      queue_random(150);
      @(posedge clock);
      while (expected_res.size() <= 20) @(posedge clock);
      // sender pauses mid-stream until every outstanding result is back
      hold_sender = 1'b1;
      while (req_tvalid || expected_res.size() > 0) @(posedge clock);
      hold_sender = 1'b0;
      queue_random(100);

      set_reference(plpd_pkg::KIND_LINE, 16'($urandom), 16'($urandom), 16'($urandom),
                    9459, 9459, 9459);
      queue_random(200);

      set_reference(plpd_pkg::KIND_PLANE, 16'h7FFF, 16'h8000, 16'h7FFF, 0, 0, 16'shC000);
      queue_corners();
      queue_random(150);

      set_reference(plpd_pkg::KIND_PLANE, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'shC000, 16384, 16384);
      queue_random(150);

      set_reference(plpd_pkg::KIND_LINE, 16'h8000, 16'h8000, 16'h8000, 16384, 16384, 16384);
      queue_corners();
      queue_random(150);

      set_reference(plpd_pkg::KIND_INVALID, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'shC000, 16'shC000, 16'shC000);
      queue_random(100);

      for (int ph = 0; ph < 6; ph++) begin
         set_reference(2'($urandom_range(2)), 16'($urandom), 16'($urandom), 16'($urandom),
                       rand_unit(), rand_unit(), rand_unit());
         queue_random(110);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (!failed && expected_res.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
